@@ design/status_led_ip_digit_blinker_top_macros.svh @@
// Assertion helpers used by the blinker top module.
`ifndef STATUS_LED_IP_DIGIT_BLINKER_TOP_MACROS_SVH
`define STATUS_LED_IP_DIGIT_BLINKER_TOP_MACROS_SVH

// Condition must hold in the same cycle as the antecedent.
`define SLDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define SLDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sldb_pkg.sv @@
package sldb_pkg;

  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
  localparam logic [15:0] RELEASE_QUIET_RST = 16'd500;

  localparam logic [3:0] LED1 = 4'b0001;
  localparam logic [3:0] LED4 = 4'b1000;

  // register indexes
  localparam logic REG_BLINK_PERIOD = 1'b0;
  localparam logic REG_RELEASE_QUIET = 1'b1;

  typedef struct packed {
    logic       radio_irq_level;
    logic [7:0] ip_last_octet;
    logic       network_ready;
    logic       system_running;
    logic       bus_blocked;
    logic       capture_busy;
    logic       button_level;
    logic [31:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Decimal split of an octet; tens via reciprocal multiply (x*205)>>11, exact for x < 100.
  function automatic digits_t split_octet(input logic [7:0] octet);
    digits_t    d;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [7:0] tens_x10;
    if (octet >= 8'd200) begin
      d.hundreds = 2'd2;
      rem = 7'(octet - 8'd200);
    end else if (octet >= 8'd100) begin
      d.hundreds = 2'd1;
      rem = 7'(octet - 8'd100);
    end else begin
      d.hundreds = 2'd0;
      rem = octet[6:0];
    end
    prod = 15'({8'd0, rem} * 15'd205);
    d.tens = prod[14:11];
    tens_x10 = 8'({4'd0, d.tens} * 8'd10);
    d.ones = 4'({1'b0, rem} - tens_x10);
    return d;
  endfunction

endpackage

@@ design/status_led_ip_digit_blinker_top.sv @@
// Channel  | Dir | Signals                        | Transaction
// in       | in  | in_tvalid/in_tready/in_tdata   | one scheduler tick
// out      | out | out_tvalid/out_tready/out_tdata| one LED/button result per tick
// cfg      | in  | cfg_psel..cfg_prdata (APB)     | register write/read
//
// One tick per clock while the output is not stalled: the tick is evaluated combinationally against the
// state registers and the result lands in the output register in the next cycle.
// A new tick is taken while the output register is empty or being drained.
// If out_tready stays low, the held result blocks in_tready until it is taken.
// rst_n is synchronous, active low; state clears and registers return to 500 ms.
module status_led_ip_digit_blinker_top import sldb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [32] button_level, [33] capture_busy, [34] bus_blocked,
  // [35] system_running, [36] network_ready, [44:37] ip_last_octet,
  // [45] radio_irq_level, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] led_levels, [4] stop_logging, [5] button_latched, [7:6] zero
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "status_led_ip_digit_blinker_top_macros.svh"

  logic [15:0] blink_period_r;
  logic [15:0] release_quiet_r;
  logic        cfg_wr;
  logic        tick_en;
  tick_t       tick;
  logic        stop_nxt, held_nxt;
  logic [3:0]  led_nxt;
  logic        out_valid_r;
  logic [7:0]  out_data_r;

  assign tick = tick_t'(in_tdata[45:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign tick_en = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_RELEASE_QUIET) ? {16'd0, release_quiet_r}
                                                          : {16'd0, blink_period_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= BLINK_PERIOD_RST;
      release_quiet_r <= RELEASE_QUIET_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BLINK_PERIOD:  blink_period_r <= cfg_pwdata[15:0];
        REG_RELEASE_QUIET: release_quiet_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  sldb_debounce u_debounce (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_en          (tick_en),
    .tick             (tick),
    .release_quiet_ms (release_quiet_r),
    .stop_nxt         (stop_nxt),
    .held_nxt         (held_nxt)
  );

  sldb_display u_display (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick_en         (tick_en),
    .tick            (tick),
    .blink_period_ms (blink_period_r),
    .led_nxt         (led_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      out_data_r <= {2'b00, held_nxt, stop_nxt, led_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  `SLDB_ASSERT_NEXT(a_accept_fills_out, tick_en, out_valid_r, "accepted tick produced no result")
  `SLDB_ASSERT_NEXT(a_busy_shows_led1, tick_en && tick.capture_busy, out_data_r[3:0] == LED1, "capture busy but LEDs not frozen on LED1")
  `SLDB_ASSERT_NOW(a_stop_implies_held, out_valid_r && out_data_r[4], out_data_r[5], "stop request without latched button")

endmodule

@@ design/sldb_debounce.sv @@
module sldb_debounce import sldb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick_en,
  input  tick_t       tick,
  input  logic [15:0] release_quiet_ms,
  output logic        stop_nxt,
  output logic        held_nxt
);

  logic [31:0] press_time_r, press_time_nxt;
  logic        press_held_r;
  logic [31:0] since_press;

  assign since_press = tick.now_ms - press_time_r;

  always_comb begin
    stop_nxt = 1'b0;
    press_time_nxt = press_time_r;
    held_nxt = press_held_r;
    if (!press_held_r && tick.button_level) begin
      stop_nxt = 1'b1;
      press_time_nxt = tick.now_ms;
      held_nxt = 1'b1;
    end else if (press_held_r && tick.button_level) begin
      press_time_nxt = tick.now_ms;
    end else if (press_held_r && (since_press > {16'd0, release_quiet_ms})) begin
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r <= '0;
      press_held_r <= 1'b0;
    end else if (tick_en) begin
      press_time_r <= press_time_nxt;
      press_held_r <= held_nxt;
    end
  end

endmodule

@@ design/sldb_display.sv @@
module sldb_display import sldb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick_en,
  input  tick_t       tick,
  input  logic [15:0] blink_period_ms,
  output logic [3:0]  led_nxt
);

  logic [31:0] blink_time_r, blink_time_nxt;
  digits_t     digits_r, digits_nxt, split;
  logic [4:0]  step_r, step_nxt;
  logic        captured_r, captured_nxt;
  logic        bus_seen_r, bus_seen_nxt;
  logic        frozen_r, frozen_nxt;
  logic [3:0]  led_r;
  logic        blink;
  logic [3:0]  half;
  logic [31:0] since_blink;

  assign split = split_octet(tick.ip_last_octet);

  always_comb begin
    blink_time_nxt = blink_time_r;
    digits_nxt = digits_r;
    step_nxt = step_r;
    captured_nxt = captured_r;
    bus_seen_nxt = bus_seen_r;
    frozen_nxt = frozen_r;
    led_nxt = led_r;
    blink = 1'b0;
    half = '0;
    since_blink = '0;

    if (tick.capture_busy != frozen_r) begin
      frozen_nxt = tick.capture_busy;
      if (tick.capture_busy) begin
        led_nxt = LED1;
      end else begin
        led_nxt = '0;
        blink_time_nxt = tick.now_ms;
      end
    end

    if (!frozen_nxt) begin
      since_blink = tick.now_ms - blink_time_nxt;
      if (since_blink >= {16'd0, blink_period_ms}) begin
        blink_time_nxt = tick.now_ms;
        blink = 1'b1;
      end

      if (tick.bus_blocked != bus_seen_r) begin
        bus_seen_nxt = tick.bus_blocked;
        if (tick.bus_blocked) begin
          led_nxt = LED1 | (tick.system_running ? LED4 : 4'b0000);
        end else begin
          step_nxt = '0;
          led_nxt = (tick.system_running && tick.radio_irq_level) ? LED4 : 4'b0000;
        end
      end

      if (!tick.bus_blocked && blink) begin
        if (tick.system_running) begin
          if (tick.network_ready) begin
            if (!captured_r) begin
              // first boundary with a link: sample the octet and restart flashing
              captured_nxt = 1'b1;
              digits_nxt = split;
              step_nxt = '0;
            end else begin
              led_nxt = {tick.radio_irq_level, led_nxt[2:0]};
            end
            half = step_nxt[4:1];
            if (!step_nxt[0]) begin
              led_nxt = led_nxt & LED4;
            end else begin
              if (half < {2'd0, digits_nxt.hundreds}) led_nxt[0] = 1'b1;
              if (half < digits_nxt.tens) led_nxt[1] = 1'b1;
              if (half < digits_nxt.ones) led_nxt[2] = 1'b1;
            end
            if (half >= {2'd0, digits_nxt.hundreds} && half >= digits_nxt.tens &&
                half >= digits_nxt.ones) begin
              step_nxt = '0;
            end else begin
              step_nxt = step_nxt + 5'd1;
            end
          end else begin
            led_nxt = led_nxt ^ LED4;
          end
        end else begin
          captured_nxt = 1'b0;
          led_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_time_r <= '0;
      digits_r <= '0;
      step_r <= '0;
      captured_r <= 1'b0;
      bus_seen_r <= 1'b0;
      frozen_r <= 1'b0;
      led_r <= '0;
    end else if (tick_en) begin
      blink_time_r <= blink_time_nxt;
      digits_r <= digits_nxt;
      step_r <= step_nxt;
      captured_r <= captured_nxt;
      bus_seen_r <= bus_seen_nxt;
      frozen_r <= frozen_nxt;
      led_r <= led_nxt;
    end
  end

endmodule

@@ dv/status_led_ip_digit_blinker_top_tb.sv @@
module status_led_ip_digit_blinker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sldb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 200;

  typedef struct packed {
    logic       button_latched;
    logic       stop_logging;
    logic [3:0] led_levels;
  } led_result_t;

  typedef struct {
    tick_t       t;
    bit          typed;
    led_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  status_led_ip_digit_blinker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the block's registers and state
  logic [15:0] period_ms;
  logic [15:0] quiet_ms;
  logic [31:0] press_ms;
  logic        btn_held;
  logic [31:0] blink_ms;
  logic [1:0]  dig_h;
  logic [3:0]  dig_t;
  logic [3:0]  dig_o;
  logic [4:0]  flash_idx;
  logic        octet_taken;
  logic        bus_seen;
  logic        frozen;
  logic [3:0]  leds;

  led_result_t expected_leds[$];
  int          bad_count = 0;
  int          idle_cycles = 0;
  bit          tx_gappy = 1'b1;
  bit          rx_gappy = 1'b1;

  // sticky stimulus state for the random part
  logic [31:0] clock_ms = 32'd0;
  logic        s_btn = 1'b0;
  logic        s_busy = 1'b0;
  logic        s_bus = 1'b0;
  logic        s_run = 1'b1;
  logic        s_net = 1'b1;
  logic        s_irq = 1'b0;

  function automatic void note_bad(input string what);
    bad_count++;
    if (bad_count <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
  endfunction

  function automatic led_result_t advance_blinker(input tick_t t);
    led_result_t r;
    logic        stop_now;
    logic        blink_now;
    logic [3:0]  half;
    stop_now = 1'b0;
    blink_now = 1'b0;

    if (!btn_held && t.button_level) begin
      stop_now = 1'b1;
      press_ms = t.now_ms;
      btn_held = 1'b1;
    end else if (btn_held && t.button_level) begin
      press_ms = t.now_ms;
    end else if (btn_held && 32'(t.now_ms - press_ms) > {16'h0, quiet_ms}) begin
      btn_held = 1'b0;
    end

    if (t.capture_busy != frozen) begin
      frozen = t.capture_busy;
      if (frozen) begin
        leds = LED1;
      end else begin
        leds = 4'h0;
        blink_ms = t.now_ms;
      end
    end

    if (!frozen) begin
      if (32'(t.now_ms - blink_ms) >= {16'h0, period_ms}) begin
        blink_ms = t.now_ms;
        blink_now = 1'b1;
      end

      if (t.bus_blocked != bus_seen) begin
        bus_seen = t.bus_blocked;
        if (t.bus_blocked) begin
          leds = LED1 | (t.system_running ? LED4 : 4'h0);
        end else begin
          flash_idx = 5'd0;
          leds = (t.system_running && t.radio_irq_level) ? LED4 : 4'h0;
        end
      end

      if (!t.bus_blocked && blink_now) begin
        if (t.system_running) begin
          if (t.network_ready) begin
            if (!octet_taken) begin
              octet_taken = 1'b1;
              dig_h = 2'(t.ip_last_octet / 8'd100);
              dig_t = 4'((t.ip_last_octet % 8'd100) / 8'd10);
              dig_o = 4'(t.ip_last_octet % 8'd10);
              flash_idx = 5'd0;
            end else begin
              leds = {t.radio_irq_level, leds[2:0]};
            end
            half = flash_idx[4:1];
            // even steps blank the digit LEDs, odd steps light the ones still counting
            if (!flash_idx[0]) begin
              leds &= LED4;
            end else begin
              if (half < dig_h) leds[0] = 1'b1;
              if (half < dig_t) leds[1] = 1'b1;
              if (half < dig_o) leds[2] = 1'b1;
            end
            if (half >= dig_h && half >= dig_t && half >= dig_o) flash_idx = 5'd0;
            else flash_idx = flash_idx + 5'd1;
          end else begin
            leds ^= LED4;
          end
        end else begin
          octet_taken = 1'b0;
          leds = 4'h0;
        end
      end
    end

    r.led_levels = leds;
    r.stop_logging = stop_now;
    r.button_latched = btn_held;
    return r;
  endfunction

  function automatic tick_t mk_tick(input logic [31:0] now, input logic btn, input logic busy,
                                    input logic bus, input logic run, input logic net,
                                    input logic [7:0] octet, input logic irq);
    tick_t k;
    k.now_ms = now;
    k.button_level = btn;
    k.capture_busy = busy;
    k.bus_blocked = bus;
    k.system_running = run;
    k.network_ready = net;
    k.ip_last_octet = octet;
    k.radio_irq_level = irq;
    return k;
  endfunction

  function automatic led_result_t mk_res(input logic [3:0] l, input logic stop,
                                         input logic held);
    led_result_t r;
    r.led_levels = l;
    r.stop_logging = stop;
    r.button_latched = held;
    return r;
  endfunction

  // one tick transaction; typed rows override the predicted result
  task automatic send_tick(input tick_t t, input bit typed, input led_result_t want);
    int          gap;
    led_result_t r;
    gap = tx_gappy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, t};
    do @(posedge clk); while (!in_tready);
    r = advance_blinker(t);
    expected_leds.push_back(typed ? want : r);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_BLINK_PERIOD) period_ms = val;
    else quiet_ms = val;
    // read back through a second transaction
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'h0, val})
      note_bad($sformatf("reg %0d read exp %h got %h", idx, {16'h0, val}, cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_ticks(input int count);
    int    step_max;
    tick_t t;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_gappy = $urandom_range(0, 1);
        rx_gappy = $urandom_range(0, 1);
      end
      step_max = (period_ms > 16'd1000) ? 1000 : int'(period_ms) + 40;
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
      else if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 70000);
      else clock_ms += $urandom_range(0, step_max);
      if ($urandom_range(0, 4) == 0) s_btn = ~s_btn;
      if ($urandom_range(0, 29) == 0) s_busy = ~s_busy;
      if ($urandom_range(0, 24) == 0) s_bus = ~s_bus;
      if ($urandom_range(0, 39) == 0) s_run = ~s_run;
      if ($urandom_range(0, 29) == 0) s_net = ~s_net;
      if ($urandom_range(0, 2) == 0) s_irq = ~s_irq;
      t = mk_tick(clock_ms, s_btn, s_busy, s_bus, s_run, s_net, 8'($urandom()), s_irq);
      send_tick(t, 1'b0, '0);
    end
  endtask

  // result side: random stalls, in-order compare against the predictor
  initial begin
    int          gap;
    led_result_t got;
    led_result_t want;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = rx_gappy ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[5:0];
      if (expected_leds.size() == 0) begin
        note_bad($sformatf("unexpected result %h", got));
      end else begin
        want = expected_leds.pop_front();
        if (got.led_levels !== want.led_levels || got.stop_logging !== want.stop_logging ||
            got.button_latched !== want.button_latched)
          note_bad($sformatf("leds exp %h got %h, stop exp %b got %b, latched exp %b got %b",
                             want.led_levels, got.led_levels, want.stop_logging,
                             got.stop_logging, want.button_latched, got.button_latched));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t script[$];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;

    period_ms = BLINK_PERIOD_RST;
    quiet_ms = RELEASE_QUIET_RST;
    press_ms = '0;
    btn_held = 1'b0;
    blink_ms = '0;
    dig_h = '0;
    dig_t = '0;
    dig_o = '0;
    flash_idx = '0;
    octet_taken = 1'b0;
    bus_seen = 1'b0;
    frozen = 1'b0;
    leds = 4'h0;

    // debounce: press, hold, quiet too short, release
    script.push_back('{mk_tick(32'd0, 0, 0, 0, 0, 0, 8'd0, 0), 1'b1, mk_res(4'h0, 0, 0)});
    script.push_back('{mk_tick(32'd100, 1, 0, 0, 0, 0, 8'd0, 0), 1'b1, mk_res(4'h0, 1, 1)});
    script.push_back('{mk_tick(32'd200, 1, 0, 0, 0, 0, 8'd0, 0), 1'b1, mk_res(4'h0, 0, 1)});
    script.push_back('{mk_tick(32'd650, 0, 0, 0, 0, 0, 8'd0, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd701, 0, 0, 0, 0, 0, 8'd0, 0), 1'b0, '0});
    // capture freezes the display, analyzer mode after unfreeze
    script.push_back('{mk_tick(32'd800, 0, 1, 0, 0, 0, 8'd0, 0), 1'b1, mk_res(LED1, 0, 0)});
    script.push_back('{mk_tick(32'd2000, 0, 1, 1, 0, 0, 8'd0, 0), 1'b1, mk_res(LED1, 0, 0)});
    script.push_back('{mk_tick(32'd2100, 0, 0, 1, 1, 0, 8'd0, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd2200, 0, 0, 0, 1, 0, 8'd0, 1), 1'b0, '0});
    // octet 255 flashes 2/5/5
    for (int i = 0; i < 7; i++)
      script.push_back('{mk_tick(32'd2700 + 32'(i) * 32'd500, 0, 0, 0, 1, 1, 8'd255,
                                 logic'(i[0])), 1'b0, '0});
    // no network toggles LED4, system down clears the capture, then octet 0
    script.push_back('{mk_tick(32'd6200, 0, 0, 0, 1, 0, 8'd17, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd6700, 0, 0, 0, 0, 1, 8'd17, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd7200, 0, 0, 0, 1, 1, 8'd0, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd7700, 0, 0, 0, 1, 1, 8'd100, 1), 1'b0, '0});
    // timestamp wrap across the debounce window
    script.push_back('{mk_tick(32'hFFFF_FFFF, 1, 0, 0, 1, 1, 8'd199, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd499, 0, 0, 0, 1, 1, 8'd199, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd500, 0, 0, 0, 1, 1, 8'd199, 0), 1'b0, '0});
    script.push_back('{mk_tick(32'd600, 1, 1, 1, 1, 1, 8'hFF, 1), 1'b1, mk_res(LED1, 1, 1)});
    script.push_back('{mk_tick(32'd700, 0, 0, 0, 1, 1, 8'hFF, 1), 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_tick(script[i].t, script[i].typed, script[i].want);
    wait_for_results();

    // zero period and zero quiet time
    write_reg(REG_BLINK_PERIOD, 16'd0);
    write_reg(REG_RELEASE_QUIET, 16'd0);
    random_ticks(RANDOM_PER_PHASE);
    wait_for_results();

    write_reg(REG_BLINK_PERIOD, 16'hFFFF);
    write_reg(REG_RELEASE_QUIET, 16'hFFFF);
    random_ticks(RANDOM_PER_PHASE);
    wait_for_results();

    write_reg(REG_BLINK_PERIOD, 16'($urandom_range(1, 60)));
    write_reg(REG_RELEASE_QUIET, 16'($urandom_range(1, 900)));
    random_ticks(RANDOM_PER_PHASE);
    wait_for_results();

    write_reg(REG_BLINK_PERIOD, 16'($urandom_range(100, 2000)));
    write_reg(REG_RELEASE_QUIET, 16'($urandom_range(0, 2000)));
    random_ticks(RANDOM_PER_PHASE);
    wait_for_results();
    repeat (4) @(posedge clk);

    if (bad_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sldb_pkg.sv
design/sldb_debounce.sv
design/sldb_display.sv
design/status_led_ip_digit_blinker_top.sv
dv/status_led_ip_digit_blinker_top_tb.sv
